FILE: rtl/core/hpsd_pkg.sv
// shared types, constants and control structs for the hausdorff distance block
`timescale 1ns / 1ps

package hpsd_pkg;

    // default sizing of the point stores
    localparam int DEF_MAX_POINTS = 256;
    localparam int DEF_MAX_DIMS   = 8;

    // fixed field widths
    localparam int COORD_W    = 16;
    localparam int DIM_W      = 4;
    localparam int SQ_W       = 35;
    localparam int ROOT_W     = 18;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int RAD_W      = 2 * ROOT_STEPS;
    localparam int REM_W      = ROOT_W + 3;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd2;

    // input word
    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic                      last_element;
    } in_word_t;

    // output word
    typedef struct packed {
        logic [ROOT_W-1:0] distance;
        logic [SQ_W-1:0]   squared_distance;
        logic              overflowed;
    } out_word_t;

    // controller states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DIV,
        ST_SETUP,
        ST_READ,
        ST_SQUARE,
        ST_ACCUM,
        ST_RINIT,
        ST_ROOT,
        ST_SEND
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic div_step;
        logic loop_init;
        logic rd;
        logic mul;
        logic acc;
        logic root_init;
        logic root_step;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic div_done;
        logic empty;
        logic k_last;
        logic j_last;
        logic i_last;
        logic dir_last;
        logic root_done;
    } status_t;

endpackage

FILE: rtl/core/hpsd_ctrl.sv
// controller state machine: load, divide, nearest-point search, square root, send
`timescale 1ns / 1ps

module hpsd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  hpsd_pkg::status_t sts,
    output hpsd_pkg::cmd_t   cmd
);
    import hpsd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.loop_init = 1'b1;
                state_next = sts.empty ? ST_RINIT : ST_READ;
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.acc = 1'b1;
                if (sts.k_last && sts.j_last && sts.i_last && sts.dir_last)
                begin
                    state_next = ST_RINIT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_RINIT:
            begin
                cmd.root_init = 1'b1;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (sts.root_done)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

FILE: rtl/core/hpsd_dp.sv
// datapath: point stores, count divider, distance search and square root unit
`timescale 1ns / 1ps

module hpsd_dp #(
    parameter int MAX_POINTS = hpsd_pkg::DEF_MAX_POINTS,
    parameter int MAX_DIMS   = hpsd_pkg::DEF_MAX_DIMS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hpsd_pkg::DIM_W-1:0]    cfg_wdata,
    input  hpsd_pkg::in_word_t            in_word,
    input  hpsd_pkg::cmd_t                cmd,
    output hpsd_pkg::status_t             sts,
    output hpsd_pkg::out_word_t           out_word
);
    import hpsd_pkg::*;

    localparam int DEPTH = MAX_POINTS * MAX_DIMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(CW + 1);

    // dimension register
    logic [DIM_W-1:0] dims_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            dims_reg <= cfg_wdata;
        end
    end

    // load bookkeeping
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          ovf_res_reg;
    logic          room;

    assign room = (count_reg < CW'(DEPTH));

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.load)
        begin
            if (room)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.start)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            ovf_res_reg <= ovf_next;
        end
    end

    // point stores
    logic [COORD_W-1:0] first_mem  [DEPTH];
    logic [COORD_W-1:0] second_mem [DEPTH];
    logic [COORD_W-1:0] first_q_reg;
    logic [COORD_W-1:0] second_q_reg;
    logic [CW-1:0]      a_addr_reg;
    logic [CW-1:0]      b_addr_reg;
    logic               dir_reg;
    logic [CW-1:0]      first_addr;
    logic [CW-1:0]      second_addr;

    assign first_addr  = dir_reg ? b_addr_reg : a_addr_reg;
    assign second_addr = dir_reg ? a_addr_reg : b_addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            first_mem[count_reg[AW-1:0]] <= in_word.x_coord;
        end
        if (cmd.rd)
        begin
            first_q_reg <= first_mem[first_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            second_mem[count_reg[AW-1:0]] <= in_word.y_coord;
        end
        if (cmd.rd)
        begin
            second_q_reg <= second_mem[second_addr[AW-1:0]];
        end
    end

    // point count: restoring division of element count by dimension, one bit a step
    logic [CW-1:0]    dvd_reg;
    logic [DIM_W-1:0] rem_reg;
    logic [SW-1:0]    div_cnt_reg;
    logic [DIM_W:0]   rem_sh;
    logic             qbit;

    assign rem_sh = {rem_reg, dvd_reg[CW-1]};
    assign qbit   = (rem_sh >= {1'b0, dims_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dvd_reg     <= count_next;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg     <= CW'({dvd_reg, qbit});
            rem_reg     <= qbit ? DIM_W'(rem_sh - {1'b0, dims_reg}) : rem_sh[DIM_W-1:0];
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    assign sts.div_done = (div_cnt_reg == SW'(CW - 1));
    assign sts.empty    = (dims_reg == '0) || (dvd_reg == '0);

    // search loop counters
    logic [CW-1:0]    n_reg;
    logic [CW-1:0]    i_reg;
    logic [CW-1:0]    j_reg;
    logic [DIM_W-1:0] k_reg;

    assign sts.k_last   = (k_reg == dims_reg - 1'b1);
    assign sts.j_last   = (j_reg == n_reg - 1'b1);
    assign sts.i_last   = (i_reg == n_reg - 1'b1);
    assign sts.dir_last = dir_reg;

    // squared coordinate difference
    logic signed [COORD_W:0] diff;
    logic [COORD_W-1:0]      mag;
    logic [2*COORD_W-1:0]    sq_reg;

    assign diff = {first_q_reg[COORD_W-1], first_q_reg}
                - {second_q_reg[COORD_W-1], second_q_reg};
    assign mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            sq_reg <= mag * mag;
        end
    end

    // saturating sum, nearest and largest distances
    logic [SQ_W-1:0] acc_reg;
    logic [SQ_W-1:0] near_reg;
    logic [SQ_W-1:0] best_reg;
    logic [SQ_W:0]   sum_wide;
    logic [SQ_W-1:0] sum_sat;
    logic [SQ_W-1:0] near_new;

    assign sum_wide = {1'b0, acc_reg} + (SQ_W + 1)'(sq_reg);
    assign sum_sat  = sum_wide[SQ_W] ? '1 : sum_wide[SQ_W-1:0];
    assign near_new = (sum_sat < near_reg) ? sum_sat : near_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.loop_init)
        begin
            n_reg      <= (dims_reg == '0) ? '0 : dvd_reg;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            dir_reg    <= 1'b0;
            a_addr_reg <= '0;
            b_addr_reg <= '0;
            acc_reg    <= '0;
            near_reg   <= '1;
            best_reg   <= '0;
        end
        else if (cmd.acc)
        begin
            if (!sts.k_last)
            begin
                acc_reg    <= sum_sat;
                k_reg      <= k_reg + 1'b1;
                a_addr_reg <= a_addr_reg + n_reg;
                b_addr_reg <= b_addr_reg + n_reg;
            end
            else
            begin
                acc_reg <= '0;
                k_reg   <= '0;
                if (!sts.j_last)
                begin
                    near_reg   <= near_new;
                    j_reg      <= j_reg + 1'b1;
                    a_addr_reg <= i_reg;
                    b_addr_reg <= j_reg + 1'b1;
                end
                else
                begin
                    near_reg   <= '1;
                    j_reg      <= '0;
                    b_addr_reg <= '0;
                    if (near_new > best_reg)
                    begin
                        best_reg <= near_new;
                    end
                    if (!sts.i_last)
                    begin
                        i_reg      <= i_reg + 1'b1;
                        a_addr_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        i_reg      <= '0;
                        a_addr_reg <= '0;
                        dir_reg    <= 1'b1;
                    end
                end
            end
        end
    end

    // integer square root, two radicand bits a step
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  srem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [4:0]        root_cnt_reg;
    logic [REM_W-1:0]  srem_sh;
    logic [REM_W-1:0]  trial;
    logic              rbit;

    assign srem_sh = {srem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign rbit    = (srem_sh >= trial);

    always_ff @(posedge clk)
    begin
        if (cmd.root_init)
        begin
            rad_reg      <= RAD_W'(best_reg);
            srem_reg     <= '0;
            root_reg     <= '0;
            root_cnt_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg      <= {rad_reg[RAD_W-3:0], 2'b00};
            srem_reg     <= rbit ? (srem_sh - trial) : srem_sh;
            root_reg     <= {root_reg[ROOT_W-2:0], rbit};
            root_cnt_reg <= root_cnt_reg + 1'b1;
        end
    end

    assign sts.root_done = (root_cnt_reg == 5'(ROOT_STEPS - 1));

    // result word
    assign out_word.distance         = root_reg;
    assign out_word.squared_distance = best_reg;
    assign out_word.overflowed       = ovf_res_reg;

endmodule

FILE: rtl/core/hausdorff_point_set_distance.sv
// top level of the brute-force hausdorff distance block
`timescale 1ns / 1ps

// Words load one coordinate pair per cycle, while the block is loading, into two
// stores of MAX_POINTS*MAX_DIMS entries, column-major (element k*n+i is
// coordinate k of point i). The word with last_element set is stored and starts
// the computation: the point count n comes from a bit-serial division of the
// element count by dimension_count, then one shared subtract-square-accumulate
// unit walks both directions, with a registered store read, a registered square
// and an accumulate for each coordinate, then the square root unit resolves two
// radicand bits a step. A batch holds the input side from its last word until
// its result word is taken. Elements past the store capacity are dropped and flagged.
module hausdorff_point_set_distance #(
    parameter int MAX_POINTS = hpsd_pkg::DEF_MAX_POINTS,
    parameter int MAX_DIMS   = hpsd_pkg::DEF_MAX_DIMS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [hpsd_pkg::DIM_W-1:0] cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  hpsd_pkg::in_word_t         in_word,
    output logic                       out_valid,
    input  logic                       out_ready,
    output hpsd_pkg::out_word_t        out_word
);
    import hpsd_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // sequencer
    hpsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_word.last_element),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // stores and arithmetic
    hpsd_dp #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIMS   (MAX_DIMS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_word   (in_word),
        .cmd       (cmd),
        .sts       (sts),
        .out_word  (out_word)
    );

    // a pending result blocks loading
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input accepted while result pending");

    // the last word of a batch starts the computation
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_word.last_element) |=> (!in_ready && !out_valid))
        else $error("last word did not start computation");

    // a taken result returns the block to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> (in_ready && !out_valid))
        else $error("block did not return to loading");

endmodule

FILE: bench/hausdorff_point_set_distance_test.sv
// testbench for the brute-force hausdorff point set distance block
`timescale 1ns / 1ps

module hausdorff_point_set_distance_test;
    import hpsd_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_POINTS * DEF_MAX_DIMS;
    localparam longint unsigned SQ_LIMIT = (64'd1 << SQ_W) - 1;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [DIM_W-1:0]  cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    in_word_t          in_word = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_word_t         out_word;

    // predictor state
    logic signed [COORD_W-1:0] first_pts [STORE_DEPTH];
    logic signed [COORD_W-1:0] second_pts [STORE_DEPTH];
    int                        stored_count = 0;
    bit                        dropped_any = 1'b0;
    logic [DIM_W-1:0]          dims = DIM_RESET;
    out_word_t                 pending_results [$];

    int error_count = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_cycles = 0;

    hausdorff_point_set_distance dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always #4 clk = ~clk;

    // squared distance of two points, saturating
    function automatic longint unsigned point_dist_sq(bit a_is_first, int i, int j, int n);
        longint unsigned acc;
        longint signed   diff;
        acc = 0;
        for (int k = 0; k < dims; k++)
        begin
            if (a_is_first)
                diff = longint'(first_pts[k*n+i]) - longint'(second_pts[k*n+j]);
            else
                diff = longint'(second_pts[k*n+i]) - longint'(first_pts[k*n+j]);
            acc = acc + longint'(diff * diff);
            if (acc > SQ_LIMIT)
                acc = SQ_LIMIT;
        end
        return acc;
    endfunction

    // max over points of the nearest squared distance to the other set
    function automatic longint unsigned directed_max(bit a_is_first, int n);
        longint unsigned best;
        longint unsigned nearest;
        longint unsigned d;
        best = 0;
        for (int i = 0; i < n; i++)
        begin
            nearest = '1;
            for (int j = 0; j < n; j++)
            begin
                d = point_dist_sq(a_is_first, i, j, n);
                if (d < nearest)
                    nearest = d;
            end
            if (nearest > best)
                best = nearest;
        end
        return best;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned root;
        longint unsigned bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v)
            bitpos = bitpos >> 2;
        while (bitpos != 0)
        begin
            if (v >= root + bitpos)
            begin
                v = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end
            else
                root = root >> 1;
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    // update the predictor with one accepted word
    task automatic predict_word(in_word_t w);
        int n;
        longint unsigned fwd;
        longint unsigned bwd;
        longint unsigned sq;
        out_word_t res;
        if (stored_count < STORE_DEPTH)
        begin
            first_pts[stored_count] = w.x_coord;
            second_pts[stored_count] = w.y_coord;
            stored_count++;
        end
        else
            dropped_any = 1'b1;
        if (w.last_element)
        begin
            n = (dims == 0) ? 0 : stored_count / int'(dims);
            fwd = directed_max(1'b1, n);
            bwd = directed_max(1'b0, n);
            sq = (fwd > bwd) ? fwd : bwd;
            res.distance = ROOT_W'(floor_root(sq));
            res.squared_distance = SQ_W'(sq);
            res.overflowed = dropped_any;
            pending_results.push_back(res);
            stored_count = 0;
            dropped_any = 1'b0;
        end
    endtask

    // send one word, called at a falling edge, returns at a falling edge
    task automatic send_word(logic signed [15:0] x, logic signed [15:0] y, bit last);
        in_word_t w;
        w.x_coord = x;
        w.y_coord = y;
        w.last_element = last;
        if (burst_left == 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_word(w);
        @(negedge clk);
    endtask

    // wait until every result has arrived and the block has settled
    task automatic drain;
        if (in_valid)
            in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_dims(logic [DIM_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        dims = v;
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 255) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    // empty batch and reset dimension with two points
    task automatic test_reset_dims;
        send_word(16'sd5, -16'sd5, 1'b1);
        send_word(16'sd0, 16'sd256, 1'b0);
        send_word(16'sd256, 16'sd0, 1'b0);
        send_word(-16'sd256, 16'sd100, 1'b0);
        send_word(16'sd512, -16'sd300, 1'b1);
        drain();
    endtask

    // extremes of the coordinates, one and eight dimensions
    task automatic test_extremes;
        write_dims(4'd1);
        send_word(16'sh8000, 16'sh7fff, 1'b1);
        send_word(16'sh7fff, 16'sh8000, 1'b0);
        send_word(16'sh0000, 16'shffff, 1'b1);
        drain();
        write_dims(4'd8);
        for (int k = 0; k < 8; k++)
            send_word(16'sh8000, 16'sh7fff, k == 7);
        drain();
    endtask

    // sums that saturate, dimension above the store limit
    task automatic test_saturation;
        write_dims(4'd15);
        for (int k = 0; k < 16; k++)
            send_word(16'sh7fff, 16'sh8000, k == 15);
        drain();
    endtask

    // too few elements for one point, and dimension zero
    task automatic test_zero_points;
        write_dims(4'd8);
        send_word(16'sd1, 16'sd2, 1'b0);
        send_word(16'sd3, 16'sd4, 1'b1);
        drain();
        write_dims(4'd0);
        send_word(16'sd7, -16'sd7, 1'b0);
        send_word(16'sd9, 16'sd1, 1'b1);
        drain();
    endtask

    // fill the store past capacity, dimension zero keeps the search empty
    task automatic test_overflow;
        write_dims(4'd0);
        for (int e = 0; e < STORE_DEPTH + 3; e++)
            send_word(rand_coord(), rand_coord(), e == STORE_DEPTH + 2);
        drain();
        // a full store with the overflowing word as the last one
        for (int e = 0; e <= STORE_DEPTH; e++)
            send_word(rand_coord(), rand_coord(), e == STORE_DEPTH);
        drain();
        // flag must clear for the next batch
        write_dims(4'd1);
        send_word(16'sd1, -16'sd1, 1'b1);
        drain();
    endtask

    // random batches of small point sets with random dimension
    task automatic test_random;
        int sent;
        int n;
        int len;
        sent = 0;
        while (sent < 800)
        begin
            case ($urandom_range(0, 9))
                0: write_dims(DIM_W'($urandom_range(0, 15)));
                1: write_dims(4'd8);
                default: write_dims(DIM_W'($urandom_range(1, 8)));
            endcase
            n = $urandom_range(1, 5);
            len = (dims == 0) ? $urandom_range(1, 6) : n * int'(dims);
            if ($urandom_range(0, 3) == 0)
                len = len + $urandom_range(0, 3);
            if (len > 24)
                len = 24;
            for (int e = 0; e < len; e++)
            begin
                send_word(rand_coord(), rand_coord(), e == len - 1);
                sent++;
            end
            drain();
        end
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (stall_cycles == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_cycles = $urandom_range(10, 200);
        end
        stall_cycles--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 0);
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (out_word.distance !== want.distance)
                    report_mismatch("distance", out_word.distance, want.distance);
                if (out_word.squared_distance !== want.squared_distance)
                    report_mismatch("squared_distance", out_word.squared_distance,
                                    want.squared_distance);
                if (out_word.overflowed !== want.overflowed)
                    report_mismatch("overflowed", out_word.overflowed, want.overflowed);
            end
        end
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_dims();
        test_extremes();
        test_saturation();
        test_zero_points();
        test_overflow();
        test_random();
        if (error_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #40ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
